// ===== rtl/windowed_text_pattern_matcher_top_defines.svh =====
// ---------------------------------------------------------------------------
// windowed text pattern matcher assertion macros
// shared property forms for the matcher checks
// ---------------------------------------------------------------------------
`ifndef WINDOWED_TEXT_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WINDOWED_TEXT_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define WTPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wtpm_pkg.sv =====
// ---------------------------------------------------------------------------
// wtpm_pkg
// types and constants shared by the pattern matcher modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtpm_pkg;

    localparam int CHAR_W    = 16;
    localparam int PAT_REGS  = 4;
    localparam int PAT_CHARS = 16;
    localparam int LEN_W     = 5;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    localparam logic [CHAR_W-1:0] NBSP    = 16'h00A0;
    localparam logic [CHAR_W-1:0] NEWLINE = 16'h000A;
    localparam logic [CHAR_W-1:0] SPACE   = 16'h0020;

    typedef enum logic [2:0] {
        REG_PAT_0 = 3'd0,
        REG_PAT_1 = 3'd1,
        REG_PAT_2 = 3'd2,
        REG_PAT_3 = 3'd3,
        REG_LEN   = 3'd4,
        REG_CASE  = 3'd5,
        REG_STOP  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_REGS-1:0][DATA_W-1:0] pat;
        logic [LEN_W-1:0]                len;
        logic                            case_sensitive;
        logic                            stop_at_first;
    } t_cfg;

    typedef struct packed {
        logic              shift;
        logic              cmp_en;
        logic [CHAR_W-1:0] pat;
    } t_cell_ctrl;

endpackage

// ===== rtl/wtpm_regs.sv =====
// ---------------------------------------------------------------------------
// wtpm_regs
// apb configuration registers for the pattern matcher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtpm_regs
    import wtpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat            <= '0;
            r_cfg.len            <= '0;
            r_cfg.case_sensitive <= 1'b1;
            r_cfg.stop_at_first  <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_0: r_cfg.pat[0] <= pwdata;
                REG_PAT_1: r_cfg.pat[1] <= pwdata;
                REG_PAT_2: r_cfg.pat[2] <= pwdata;
                REG_PAT_3: r_cfg.pat[3] <= pwdata;
                REG_LEN:   r_cfg.len <= pwdata[LEN_W-1:0];
                REG_CASE:  r_cfg.case_sensitive <= pwdata[0];
                REG_STOP:  r_cfg.stop_at_first <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_0: prdata = r_cfg.pat[0];
            REG_PAT_1: prdata = r_cfg.pat[1];
            REG_PAT_2: prdata = r_cfg.pat[2];
            REG_PAT_3: prdata = r_cfg.pat[3];
            REG_LEN:   prdata = DATA_W'(r_cfg.len);
            REG_CASE:  prdata = DATA_W'(r_cfg.case_sensitive);
            REG_STOP:  prdata = DATA_W'(r_cfg.stop_at_first);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/wtpm_cell.sv =====
// ---------------------------------------------------------------------------
// wtpm_cell
// one window position: holds a character and compares it on shift
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtpm_cell
    import wtpm_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CHAR_W-1:0] i_char,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_eq
);

    logic [CHAR_W-1:0] r_char;
    logic              r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_char <= i_char;
            r_eq   <= !i_ctrl.cmp_en || (i_char == i_ctrl.pat);
        end
    end

    assign o_char = r_char;
    assign o_eq   = r_eq;

endmodule

// ===== rtl/windowed_text_pattern_matcher_top.sv =====
// ---------------------------------------------------------------------------
// windowed_text_pattern_matcher_top
// sliding window string match over a row of character cells
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_command, i_text_char
//   result    out        o_valid / i_ready      o_match, o_match_start, o_found
//   config    in         apb psel/penable       paddr, pwdata, prdata
//
// for each request, accepting a text character shifts the cell row and each
// cell registers its compare; ST_EVAL then reduces the compare bits and
// loads the result register once the output is free. one request in flight.
// reset is synchronous and active low; no clearing pass.
// a stalled result holds o_ready low until it is taken; the evaluate state
// also waits for it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_text_pattern_matcher_top_defines.svh"

module windowed_text_pattern_matcher_top
    import wtpm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [CHAR_W-1:0] i_text_char,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_match,
    output logic [31:0]       o_match_start,
    output logic              o_found,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } t_state;

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] res;
        res = c;
        if (c >= 16'h0041 && c <= 16'h005A) res = c + 16'h0020;
        else if (c >= 16'h00C0 && c <= 16'h00DE && c != 16'h00D7) res = c + 16'h0020;
        else if (c >= 16'h0391 && c <= 16'h03A9 && c != 16'h03A2) res = c + 16'h0020;
        else if (c >= 16'h0410 && c <= 16'h042F) res = c + 16'h0020;
        else if (c >= 16'h0400 && c <= 16'h040F) res = c + 16'h0050;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] normalise(input logic [CHAR_W-1:0] c,
                                                    input logic cs);
        logic [CHAR_W-1:0] res;
        res = c;
        if (c == NBSP) res = SPACE;
        else if (!cs) res = to_lower(c);
        return res;
    endfunction

    t_cfg              w_cfg;
    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [31:0]       r_offset, n_offset;
    logic              r_found, n_found;
    logic              r_is_break, n_is_break;
    logic              r_out_valid, n_out_valid;
    logic              r_match;
    logic [31:0]       r_start;
    logic              r_found_out;

    logic              w_accept;
    logic              w_shift;
    logic              w_load;
    logic              w_newline;
    logic              w_hit;
    logic [CHAR_W-1:0] w_in_norm;
    logic [CHAR_W-1:0] w_pat_n [PAT_CHARS];

    t_cell_ctrl        w_ctrl [MAX_PATTERN];
    logic [CHAR_W-1:0] w_q    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;

    wtpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // normalised pattern and newline scan
    always_comb begin
        w_newline = 1'b0;
        for (int i = 0; i < PAT_CHARS; i++) begin
            w_pat_n[i] = normalise(w_cfg.pat[i / 4][(i % 4) * CHAR_W +: CHAR_W],
                                   w_cfg.case_sensitive);
            if ((LEN_W'(i) < w_cfg.len) &&
                (w_cfg.pat[i / 4][(i % 4) * CHAR_W +: CHAR_W] == NEWLINE)) begin
                w_newline = 1'b1;
            end
        end
    end

    assign o_ready   = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign w_accept  = i_valid && o_ready;
    assign w_shift   = w_accept && !i_command;
    assign w_in_norm = normalise(i_text_char, w_cfg.case_sensitive);
    assign w_load    = (r_state == ST_EVAL) && (!r_out_valid || i_ready);

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [6:0] w_idx;
        assign w_idx = 7'(w_cfg.len) - 7'(k) - 7'd1;
        assign w_ctrl[k].shift  = w_shift;
        assign w_ctrl[k].cmp_en = 7'(k) < 7'(w_cfg.len);
        assign w_ctrl[k].pat    = (w_idx < 7'(PAT_CHARS)) ? w_pat_n[w_idx[3:0]] : '0;

        if (k == 0) begin : g_head
            wtpm_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl[k]),
                .i_char (w_in_norm),
                .o_char (w_q[k]),
                .o_eq   (w_eq[k])
            );
        end else begin : g_body
            wtpm_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl[k]),
                .i_char (w_q[k-1]),
                .o_char (w_q[k]),
                .o_eq   (w_eq[k])
            );
        end
    end

    assign w_hit = !r_is_break && (w_cfg.len != '0) &&
                   (CW'(w_cfg.len) <= CW'(MAX_PATTERN)) &&
                   (CW'(r_fill) >= CW'(w_cfg.len)) && !w_newline && (&w_eq) &&
                   !(w_cfg.stop_at_first && r_found);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_offset    = r_offset;
        n_found     = r_found;
        n_is_break  = r_is_break;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state    = ST_EVAL;
                    n_is_break = i_command;
                    if (i_command) begin
                        n_fill = '0;
                    end else begin
                        if (r_fill != FW'(MAX_PATTERN)) n_fill = r_fill + 1'b1;
                        if (r_offset != '1) n_offset = r_offset + 32'd1;
                    end
                end
            end
            ST_EVAL: begin
                if (w_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (w_hit) n_found = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_offset    <= '0;
            r_found     <= 1'b0;
            r_is_break  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_offset    <= n_offset;
            r_found     <= n_found;
            r_is_break  <= n_is_break;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_match     <= w_hit;
            r_start     <= w_hit ? (r_offset - 32'(w_cfg.len)) : '0;
            r_found_out <= r_found || w_hit;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match       = r_match;
    assign o_match_start = r_start;
    assign o_found       = r_found_out;

    `WTPM_ASSERT_IMP(a_rose_after_eval, i_clk, i_rst_n, $rose(o_valid),
        $past(r_state == ST_EVAL), "result appeared without an evaluate cycle")
    `WTPM_ASSERT_IMP(a_match_sets_found, i_clk, i_rst_n, o_valid && o_match,
        o_found, "match reported without found")
    `WTPM_ASSERT_NXT(a_break_clears_fill, i_clk, i_rst_n, w_accept && i_command,
        r_fill == '0, "break did not empty the window")
    `WTPM_ASSERT_NXT(a_found_sticks, i_clk, i_rst_n, r_found,
        r_found, "found latch dropped")
    `WTPM_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1,
        CW'(r_fill) <= CW'(MAX_PATTERN), "fill count beyond window depth")

endmodule
